[src/assert_macros.svh]
// assertion macros used by the checker in mtsm_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MTSM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MTSM_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/mtsm_pkg.sv]
package mtsm_pkg;

  localparam logic [15:0] TYPE_SYN       = 16'd0;
  localparam logic [15:0] TYPE_ABS       = 16'd3;
  localparam logic [15:0] CODE_SYN_REPORT = 16'd0;
  localparam logic [15:0] CODE_SLOT      = 16'h002f;
  localparam logic [15:0] CODE_TRACK     = 16'h0039;
  localparam logic [15:0] CODE_PX        = 16'h0035;
  localparam logic [15:0] CODE_PY        = 16'h0036;

  localparam logic [19:0] PHYS_TRACK_BASE = 20'd114514;
  localparam logic [19:0] VIRT_TRACK_BASE = 20'd415411;

  localparam logic [1:0] KIND_PHYS  = 2'd0;
  localparam logic [1:0] KIND_DOWN  = 2'd1;
  localparam logic [1:0] KIND_MOVE  = 2'd2;
  localparam logic [1:0] KIND_UP    = 2'd3;

  localparam logic [1:0] REC_CONTACT = 2'd0;
  localparam logic [1:0] REC_FRAME   = 2'd1;
  localparam logic [1:0] REC_NOTICE  = 2'd2;

  localparam logic [2:0] CFG_ORIENT  = 3'd0;
  localparam logic [2:0] CFG_SCR_W   = 3'd1;
  localparam logic [2:0] CFG_SCR_H   = 3'd2;
  localparam logic [2:0] CFG_T2S     = 3'd3;
  localparam logic [2:0] CFG_S2T     = 3'd4;
  localparam logic [2:0] CFG_MON     = 3'd5;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic        start;
    logic        op;
    logic        neg;
    logic [17:0] mag;
    logic [15:0] factor;
  } arith_req_t;

  typedef struct packed {
    logic               done;
    logic signed [16:0] value;
  } arith_rsp_t;

endpackage

[src/mtsm_in_if.sv]
interface mtsm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [15:0]        ev_type;
  logic [15:0]        ev_code;
  logic signed [31:0] ev_value;
  logic [15:0]        virt_id;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;

  modport source (output valid, kind, ev_type, ev_code, ev_value, virt_id, pos_x, pos_y,
                  input ready);
  modport sink (input valid, kind, ev_type, ev_code, ev_value, virt_id, pos_x, pos_y,
                output ready);
endinterface

[src/mtsm_out_if.sv]
interface mtsm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         rec_kind;
  logic [19:0]        track_id;
  logic signed [16:0] out_x;
  logic signed [16:0] out_y;
  logic [3:0]         notice_slot;
  logic               notice_up;
  logic               last;

  modport source (output valid, rec_kind, track_id, out_x, out_y, notice_slot, notice_up,
                  last, input ready);
  modport sink (input valid, rec_kind, track_id, out_x, out_y, notice_slot, notice_up,
                last, output ready);
  modport monitor (input valid, ready, rec_kind, track_id, out_x, out_y, notice_slot,
                   notice_up, last);
endinterface

[src/mtsm_cfg_if.sv]
interface mtsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/multitouch_slot_merger_core.sv]
// channel | dir | beat carries
// in_bus  | in  | kind, ev_type, ev_code, ev_value, virt_id, pos_x, pos_y
// out_bus | out | rec_kind, track_id, out_x, out_y, notice_slot, notice_up, last
// cfg_bus | in  | index, data (always ready)
// an item that causes no records leaves the block idle; a report or accepted virtual up walks all
// 2*SLOTS contact entries, one per cycle unless out_bus stalls, and then emits a frame end record.
// a virtual down or move first rotates, runs the shared unit as a divider twice and writes back;
// a notice on a down slot runs it as a multiplier twice.
// rst_n is synchronous, clears all contact state and sets the config registers to their defaults.
// a stalled out_bus holds the walk; in_bus is ready only while no item is in progress.
module multitouch_slot_merger_core #(
  parameter int SLOTS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  mtsm_in_if.sink     in_bus,
  mtsm_out_if.source  out_bus,
  mtsm_cfg_if.sink    cfg_bus
);

  localparam int ENTRIES = 2 * SLOTS;
  localparam int EW = $clog2(ENTRIES);
  localparam int SW = $clog2(SLOTS);
  localparam logic [EW-1:0] LAST_ENTRY = EW'(ENTRIES - 1);
  localparam logic [EW-1:0] VIRT_BASE  = EW'(SLOTS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROT  = 4'd1;
  localparam logic [3:0] S_GOX  = 4'd2;
  localparam logic [3:0] S_WX   = 4'd3;
  localparam logic [3:0] S_WY   = 4'd4;
  localparam logic [3:0] S_NOTE = 4'd5;
  localparam logic [3:0] S_VWR  = 4'd6;
  localparam logic [3:0] S_UPL  = 4'd7;
  localparam logic [3:0] S_FEND = 4'd8;

  logic [3:0] state_r, state_nxt;

  logic [1:0]  orient_r;
  logic [15:0] scr_w_r, scr_h_r, t2s_r, s2t_r;
  logic        mon_r;

  logic [SW-1:0]      cur_slot_r;
  logic [ENTRIES-1:0] down_r, used_r;
  logic signed [16:0] x_r [ENTRIES];
  logic signed [16:0] y_r [ENTRIES];
  logic [19:0]        track_r [ENTRIES];
  logic [15:0]        owner_r [SLOTS];

  logic [1:0]         kind_r;
  logic [15:0]        id_r;
  logic signed [16:0] px_r, py_r;
  logic               note_r, note_up_r;
  logic [SW-1:0]      vent_r;
  logic [EW-1:0]      idx_r;
  logic signed [17:0] rot_x_r, rot_y_r;
  logic signed [16:0] res_x_r, res_y_r;

  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [19:0]        out_track_r;
  logic signed [16:0] out_x_r, out_y_r;
  logic [3:0]         out_slot_r;
  logic               out_up_r, out_last_r;

  mtsm_pkg::arith_req_t req;
  mtsm_pkg::arith_rsp_t rsp;

  logic          accept, out_free, emit;
  logic          is_abs, is_report;
  logic          free_hit, own_hit, own_ok;
  logic [SW-1:0] free_idx, own_idx;
  logic [EW-1:0] own_ent, cur_ent, rd_addr, vent_ent;
  logic          slot_ok;

  logic signed [17:0] sx, sy, rx, ry;
  logic signed [18:0] w19, h19;

  function automatic logic signed [16:0] sat17(input logic signed [31:0] v);
    if (v > 32'sd65535)       return 17'sh0ffff;
    else if (v < -32'sd65536) return 17'sh10000;
    else                      return v[16:0];
  endfunction

  assign accept    = in_bus.valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_bus.ready;
  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;

  // a record is loaded into the output register this cycle
  assign emit = out_free && ((state_r == S_NOTE) || (state_r == S_FEND) ||
                             ((state_r == S_UPL) && down_r[idx_r]));

  assign is_abs    = (in_bus.kind == mtsm_pkg::KIND_PHYS) && (in_bus.ev_type == mtsm_pkg::TYPE_ABS);
  assign is_report = (in_bus.kind == mtsm_pkg::KIND_PHYS) && (in_bus.ev_type == mtsm_pkg::TYPE_SYN)
                     && (in_bus.ev_code == mtsm_pkg::CODE_SYN_REPORT);
  assign slot_ok   = !in_bus.ev_value[31] && (in_bus.ev_value[30:0] < 31'(SLOTS));
  assign cur_ent   = EW'(cur_slot_r);
  assign vent_ent  = VIRT_BASE + EW'(vent_r);
  assign rd_addr   = (state_r == S_UPL) ? idx_r : cur_ent;

  // first free virtual entry and first entry owned by the caller id
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    own_hit  = 1'b0;
    own_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[SLOTS + i]) begin
        free_hit = 1'b1;
        free_idx = SW'(i);
      end
      if (owner_r[i] == in_bus.virt_id) begin
        own_hit = 1'b1;
        own_idx = SW'(i);
      end
    end
  end

  assign own_ent = VIRT_BASE + EW'(own_idx);
  assign own_ok  = own_hit && used_r[own_ent] && down_r[own_ent];

  // rotation: forward for notices, back for virtual positions
  always_comb begin
    sx  = note_r ? 18'(x_r[rd_addr]) : 18'(px_r);
    sy  = note_r ? 18'(y_r[rd_addr]) : 18'(py_r);
    w19 = $signed({3'b0, scr_w_r});
    h19 = $signed({3'b0, scr_h_r});
    rx  = sx;
    ry  = sy;
    case (orient_r)
      2'd1: begin
        ry = note_r ? 18'(h19 - 19'(sx)) : sx;
        rx = note_r ? sy : 18'(w19 - 19'(sy));
      end
      2'd2: begin
        rx = 18'(w19 - 19'(sx));
        ry = 18'(h19 - 19'(sy));
      end
      2'd3: begin
        ry = note_r ? sx : 18'(h19 - 19'(sx));
        rx = note_r ? 18'(w19 - 19'(sy)) : sy;
      end
      default: ;
    endcase
  end

  always_comb begin
    logic signed [17:0] opnd;
    opnd       = (state_r == S_GOX) ? rot_x_r : rot_y_r;
    req.start  = (state_r == S_GOX) || ((state_r == S_WX) && rsp.done);
    req.op     = note_r ? mtsm_pkg::OP_MUL : mtsm_pkg::OP_DIV;
    req.neg    = opnd[17];
    req.mag    = opnd[17] ? 18'(-opnd) : opnd;
    req.factor = note_r ? t2s_r : ((s2t_r == 16'd0) ? 16'd1 : s2t_r);
  end

  mtsm_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_report) begin
            if (!mon_r)                state_nxt = S_UPL;
            else if (down_r[cur_ent])  state_nxt = S_ROT;
            else                       state_nxt = S_NOTE;
          end else if (in_bus.kind == mtsm_pkg::KIND_DOWN) begin
            if (free_hit) state_nxt = S_ROT;
          end else if (in_bus.kind == mtsm_pkg::KIND_MOVE) begin
            if (own_ok) state_nxt = S_ROT;
          end else if (in_bus.kind == mtsm_pkg::KIND_UP) begin
            if (own_ok) state_nxt = S_UPL;
          end
        end
      end
      S_ROT:  state_nxt = S_GOX;
      S_GOX:  state_nxt = S_WX;
      S_WX:   if (rsp.done) state_nxt = S_WY;
      S_WY:   if (rsp.done) state_nxt = note_r ? S_NOTE : S_VWR;
      S_NOTE: if (out_free) state_nxt = S_UPL;
      S_VWR:  state_nxt = S_UPL;
      S_UPL:  if ((!down_r[idx_r] || out_free) && idx_r == LAST_ENTRY) state_nxt = S_FEND;
      S_FEND: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      orient_r    <= 2'd0;
      scr_w_r     <= 16'd1080;
      scr_h_r     <= 16'd2400;
      t2s_r       <= 16'd256;
      s2t_r       <= 16'd256;
      mon_r       <= 1'b0;
      cur_slot_r  <= '0;
      down_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      note_r      <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        x_r[i]     <= '0;
        y_r[i]     <= '0;
        track_r[i] <= '0;
      end
      for (int i = 0; i < SLOTS; i++) begin
        owner_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_bus.valid) begin
        unique case (cfg_bus.index)
          mtsm_pkg::CFG_ORIENT: orient_r <= cfg_bus.data[1:0];
          mtsm_pkg::CFG_SCR_W:  scr_w_r  <= cfg_bus.data;
          mtsm_pkg::CFG_SCR_H:  scr_h_r  <= cfg_bus.data;
          mtsm_pkg::CFG_T2S:    t2s_r    <= cfg_bus.data;
          mtsm_pkg::CFG_S2T:    s2t_r    <= cfg_bus.data;
          mtsm_pkg::CFG_MON:    mon_r    <= cfg_bus.data[0];
          default: ;
        endcase
      end

      if (emit)               out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;

      if (state_r != S_UPL) idx_r <= '0;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r <= in_bus.kind;
            id_r   <= in_bus.virt_id;
            px_r   <= in_bus.pos_x;
            py_r   <= in_bus.pos_y;
            if (is_abs) begin
              case (in_bus.ev_code)
                mtsm_pkg::CODE_SLOT: begin
                  if (slot_ok) begin
                    cur_slot_r <= in_bus.ev_value[SW-1:0];
                    track_r[EW'(in_bus.ev_value[SW-1:0])] <=
                      mtsm_pkg::PHYS_TRACK_BASE + 20'(in_bus.ev_value[SW-1:0]);
                  end else begin
                    cur_slot_r <= '0;
                  end
                end
                mtsm_pkg::CODE_TRACK: begin
                  if (in_bus.ev_value == -32'sd1) begin
                    down_r[cur_ent] <= 1'b0;
                    used_r[cur_ent] <= 1'b0;
                    x_r[cur_ent]    <= '0;
                    y_r[cur_ent]    <= '0;
                  end else begin
                    down_r[cur_ent] <= 1'b1;
                    used_r[cur_ent] <= 1'b1;
                  end
                end
                mtsm_pkg::CODE_PX: x_r[cur_ent] <= sat17(in_bus.ev_value);
                mtsm_pkg::CODE_PY: y_r[cur_ent] <= sat17(in_bus.ev_value);
                default: ;
              endcase
            end
            if (is_report) begin
              note_r    <= 1'b1;
              note_up_r <= !down_r[cur_ent];
            end else begin
              note_r <= 1'b0;
            end
            if (in_bus.kind == mtsm_pkg::KIND_DOWN) vent_r <= free_idx;
            else                                    vent_r <= own_idx;
            if (in_bus.kind == mtsm_pkg::KIND_UP && own_ok) begin
              down_r[own_ent]  <= 1'b0;
              used_r[own_ent]  <= 1'b0;
              owner_r[own_idx] <= '0;
            end
          end
        end
        S_ROT: begin
          rot_x_r <= rx;
          rot_y_r <= ry;
        end
        S_WX: if (rsp.done) res_x_r <= rsp.value;
        S_WY: if (rsp.done) res_y_r <= rsp.value;
        S_NOTE: begin
          if (out_free) begin
            out_kind_r  <= mtsm_pkg::REC_NOTICE;
            out_track_r <= '0;
            out_x_r     <= note_up_r ? 17'sd0 : res_x_r;
            out_y_r     <= note_up_r ? 17'sd0 : res_y_r;
            out_slot_r  <= 4'(cur_slot_r);
            out_up_r    <= note_up_r;
            out_last_r  <= 1'b0;
          end
        end
        S_VWR: begin
          x_r[vent_ent] <= res_x_r;
          y_r[vent_ent] <= res_y_r;
          if (kind_r == mtsm_pkg::KIND_DOWN) begin
            down_r[vent_ent]  <= 1'b1;
            used_r[vent_ent]  <= 1'b1;
            owner_r[vent_r]   <= id_r;
            track_r[vent_ent] <= mtsm_pkg::VIRT_TRACK_BASE + 20'(id_r);
          end
        end
        S_UPL: begin
          if (!down_r[idx_r] || out_free) begin
            if (idx_r != LAST_ENTRY) idx_r <= idx_r + EW'(1);
          end
          if (down_r[idx_r] && out_free) begin
            out_kind_r  <= mtsm_pkg::REC_CONTACT;
            out_track_r <= track_r[rd_addr];
            out_x_r     <= x_r[rd_addr];
            out_y_r     <= y_r[rd_addr];
            out_slot_r  <= '0;
            out_up_r    <= 1'b0;
            out_last_r  <= 1'b0;
          end
        end
        S_FEND: begin
          if (out_free) begin
            out_kind_r  <= mtsm_pkg::REC_FRAME;
            out_track_r <= '0;
            out_x_r     <= '0;
            out_y_r     <= '0;
            out_slot_r  <= '0;
            out_up_r    <= 1'b0;
            out_last_r  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.rec_kind    = out_kind_r;
  assign out_bus.track_id    = out_track_r;
  assign out_bus.out_x       = out_x_r;
  assign out_bus.out_y       = out_y_r;
  assign out_bus.notice_slot = out_slot_r;
  assign out_bus.notice_up   = out_up_r;
  assign out_bus.last        = out_last_r;

endmodule

[src/mtsm_arith.sv]
module mtsm_arith (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mtsm_pkg::arith_req_t   req,
  output mtsm_pkg::arith_rsp_t   rsp
);

  logic        busy_r;
  logic        done_r;
  logic        op_r;
  logic        neg_r;
  logic [4:0]  cnt_r;
  logic [15:0] b_r;
  logic [25:0] a_r;
  logic [33:0] acc_r;

  logic [16:0] rem_sh;
  logic        ge;
  logic [25:0] q;

  assign rem_sh = {acc_r[15:0], a_r[25]};
  assign ge     = rem_sh >= {1'b0, b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == 5'd1);
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        neg_r  <= req.neg;
        b_r    <= req.factor;
        a_r    <= {req.mag, 8'b0};
        acc_r  <= '0;
        cnt_r  <= (req.op == mtsm_pkg::OP_DIV) ? 5'd26 : 5'd18;
      end else if (busy_r) begin
        if (op_r == mtsm_pkg::OP_DIV) begin
          // restoring division, one quotient bit per cycle
          acc_r <= {17'b0, ge ? (rem_sh - {1'b0, b_r}) : rem_sh};
          a_r   <= {a_r[24:0], ge};
        end else begin
          // shift-add from the top multiplier bit
          acc_r <= {acc_r[32:0], 1'b0} + (a_r[25] ? {18'b0, b_r} : 34'b0);
          a_r   <= {a_r[24:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // magnitude truncation equals truncation toward zero
  assign q = (op_r == mtsm_pkg::OP_DIV) ? a_r : acc_r[33:8];

  always_comb begin
    rsp.done = done_r;
    if (neg_r) begin
      if (q > 26'd65536) rsp.value = 17'sh10000;
      else               rsp.value = $signed(~q[16:0] + 17'd1);
    end else begin
      if (q > 26'd65535) rsp.value = 17'sh0ffff;
      else               rsp.value = $signed(q[16:0]);
    end
  end

endmodule

[src/mtsm_checker.sv]
`include "assert_macros.svh"

module mtsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_rec_kind,
  input logic [19:0] out_track_id,
  input logic [16:0] out_x,
  input logic [3:0]  out_slot,
  input logic        out_up,
  input logic        out_last
);

  // a stalled beat keeps its kind, x and last flag
  `MTSM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_rec_kind) && $stable(out_last))

  // only the frame end closes a run
  `MTSM_ASSERT_IMP(a_last_frame, clk, rst_n, out_valid, out_last == (out_rec_kind == mtsm_pkg::REC_FRAME))

  // frame end and notice carry no tracking id
  `MTSM_ASSERT_IMP(a_track_zero, clk, rst_n, out_valid && out_rec_kind != mtsm_pkg::REC_CONTACT, out_track_id == 20'd0)

  // up flag and slot only ride on notices
  `MTSM_ASSERT_IMP(a_notice_only, clk, rst_n, out_valid && out_rec_kind != mtsm_pkg::REC_NOTICE, !out_up && out_slot == 4'd0)

endmodule

bind multitouch_slot_merger_core mtsm_checker u_mtsm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_rec_kind (out_bus.rec_kind),
  .out_track_id (out_bus.track_id),
  .out_x        (out_bus.out_x),
  .out_slot     (out_bus.notice_slot),
  .out_up       (out_bus.notice_up),
  .out_last     (out_bus.last)
);

[bench/mtsm_merge_checker.sv]
`timescale 1ns / 1ps
module mtsm_merge_checker #(
  parameter int SLOTS = 10
) (
  input  logic clk,
  input  logic rst_n,
  mtsm_in_if   in_bus,
  mtsm_out_if  out_bus,
  mtsm_cfg_if  cfg_bus,
  output int   fail_count,
  output int   records_pending
);

  localparam int ENTRIES = 2 * SLOTS;

  typedef struct packed {
    logic [1:0]         rec_kind;
    logic [19:0]        track_id;
    logic signed [16:0] out_x;
    logic signed [16:0] out_y;
    logic [3:0]         notice_slot;
    logic               notice_up;
    logic               last;
  } touch_rec_t;

  touch_rec_t expected_recs[$];

  logic [1:0]  orient;
  logic [15:0] scr_w, scr_h, t2s_q8, s2t_q8;
  logic        mon_en;

  int          cur_slot;
  bit          down_q[ENTRIES];
  bit          used_q[ENTRIES];
  int          pos_x_q[ENTRIES];
  int          pos_y_q[ENTRIES];
  logic [19:0] track_q[ENTRIES];
  logic [15:0] owner_q[SLOTS];

  function automatic int clamp17(longint v);
    if (v < -65536) return -65536;
    if (v > 65535) return 65535;
    return int'(v);
  endfunction

  // back: screen to touch direction
  function automatic void rotate(longint px, longint py, bit back,
                                 output longint rx, output longint ry);
    longint w, h;
    w = scr_w;
    h = scr_h;
    rx = px;
    ry = py;
    case (orient)
      2'd1: begin
        ry = back ? px : h - px;
        rx = back ? w - py : py;
      end
      2'd2: begin
        rx = w - px;
        ry = h - py;
      end
      2'd3: begin
        ry = back ? h - px : px;
        rx = back ? py : w - py;
      end
      default: ;
    endcase
  endfunction

  function automatic int scale_to_touch(longint v);
    longint d;
    d = (s2t_q8 == 0) ? 1 : longint'(s2t_q8);
    return clamp17((v * 256) / d);
  endfunction

  function automatic void push_rec(logic [1:0] k, logic [19:0] trk, int x, int y,
                                   int slot, bit up, bit last);
    touch_rec_t r;
    r.rec_kind    = k;
    r.track_id    = trk;
    r.out_x       = x[16:0];
    r.out_y       = y[16:0];
    r.notice_slot = slot[3:0];
    r.notice_up   = up;
    r.last        = last;
    expected_recs.insert(expected_recs.size(), r);
  endfunction

  function automatic void push_frame();
    for (int i = 0; i < ENTRIES; i++)
      if (down_q[i])
        push_rec(mtsm_pkg::REC_CONTACT, track_q[i], pos_x_q[i], pos_y_q[i], 0, 0, 0);
    push_rec(mtsm_pkg::REC_FRAME, 0, 0, 0, 0, 0, 1);
  endfunction

  function automatic void predict_beat(logic [1:0] kind, logic [15:0] typ, logic [15:0] code,
                                       logic signed [31:0] val, logic [15:0] id,
                                       logic signed [16:0] px, logic signed [16:0] py);
    longint rx, ry;
    int s, i;
    s = cur_slot;
    if (kind == mtsm_pkg::KIND_PHYS) begin
      if (typ == mtsm_pkg::TYPE_ABS) begin
        if (code == mtsm_pkg::CODE_SLOT) begin
          if (val < 0 || val >= SLOTS) cur_slot = 0;
          else begin
            cur_slot = val;
            track_q[cur_slot] = mtsm_pkg::PHYS_TRACK_BASE + 20'(cur_slot);
          end
        end else if (code == mtsm_pkg::CODE_TRACK) begin
          if (val == -1) begin
            down_q[s]  = 0;
            used_q[s]  = 0;
            pos_x_q[s] = 0;
            pos_y_q[s] = 0;
          end else begin
            down_q[s] = 1;
            used_q[s] = 1;
          end
        end else if (code == mtsm_pkg::CODE_PX) pos_x_q[s] = clamp17(val);
        else if (code == mtsm_pkg::CODE_PY) pos_y_q[s] = clamp17(val);
      end else if (typ == mtsm_pkg::TYPE_SYN && code == mtsm_pkg::CODE_SYN_REPORT) begin
        if (mon_en) begin
          if (down_q[s]) begin
            rotate(pos_x_q[s], pos_y_q[s], 0, rx, ry);
            push_rec(mtsm_pkg::REC_NOTICE, 0, clamp17(rx * longint'(t2s_q8) / 256),
                     clamp17(ry * longint'(t2s_q8) / 256), s, 0, 0);
          end else push_rec(mtsm_pkg::REC_NOTICE, 0, 0, 0, s, 1, 0);
        end
        push_frame();
      end
      return;
    end
    if (kind == mtsm_pkg::KIND_DOWN) begin
      for (i = 0; i < SLOTS; i++) if (!used_q[SLOTS + i]) break;
      if (i == SLOTS) return;
      rotate(px, py, 1, rx, ry);
      down_q[SLOTS + i]  = 1;
      used_q[SLOTS + i]  = 1;
      owner_q[i]         = id;
      track_q[SLOTS + i] = mtsm_pkg::VIRT_TRACK_BASE + 20'(id);
      pos_x_q[SLOTS + i] = scale_to_touch(rx);
      pos_y_q[SLOTS + i] = scale_to_touch(ry);
      push_frame();
      return;
    end
    for (i = 0; i < SLOTS; i++) if (owner_q[i] == id) break;
    if (i == SLOTS) return;
    if (!(used_q[SLOTS + i] && down_q[SLOTS + i])) return;
    if (kind == mtsm_pkg::KIND_MOVE) begin
      rotate(px, py, 1, rx, ry);
      pos_x_q[SLOTS + i] = scale_to_touch(rx);
      pos_y_q[SLOTS + i] = scale_to_touch(ry);
    end else begin
      down_q[SLOTS + i] = 0;
      used_q[SLOTS + i] = 0;
      owner_q[i]        = 0;
    end
    push_frame();
  endfunction

  always @(posedge clk) begin
    touch_rec_t got, exp_r;
    if (!rst_n) begin
      orient     = 0;
      scr_w      = 16'd1080;
      scr_h      = 16'd2400;
      t2s_q8     = 16'd256;
      s2t_q8     = 16'd256;
      mon_en     = 0;
      cur_slot   = 0;
      fail_count = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        down_q[i]  = 0;
        used_q[i]  = 0;
        pos_x_q[i] = 0;
        pos_y_q[i] = 0;
        track_q[i] = 0;
      end
      for (int i = 0; i < SLOTS; i++) owner_q[i] = 0;
      expected_recs.delete();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          mtsm_pkg::CFG_ORIENT: orient = cfg_bus.data[1:0];
          mtsm_pkg::CFG_SCR_W:  scr_w  = cfg_bus.data;
          mtsm_pkg::CFG_SCR_H:  scr_h  = cfg_bus.data;
          mtsm_pkg::CFG_T2S:    t2s_q8 = cfg_bus.data;
          mtsm_pkg::CFG_S2T:    s2t_q8 = cfg_bus.data;
          mtsm_pkg::CFG_MON:    mon_en = cfg_bus.data[0];
          default: ;
        endcase
      end
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.rec_kind, out_bus.track_id, out_bus.out_x, out_bus.out_y,
               out_bus.notice_slot, out_bus.notice_up, out_bus.last};
        if (expected_recs.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected record %h", $time, got);
        end else begin
          exp_r = expected_recs.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            $display("%0t: expected kind=%0d trk=%0d x=%0d y=%0d slot=%0d up=%0d last=%0d",
                     $time, exp_r.rec_kind, exp_r.track_id, exp_r.out_x, exp_r.out_y,
                     exp_r.notice_slot, exp_r.notice_up, exp_r.last);
            $display("%0t: actual   kind=%0d trk=%0d x=%0d y=%0d slot=%0d up=%0d last=%0d",
                     $time, got.rec_kind, got.track_id, got.out_x, got.out_y,
                     got.notice_slot, got.notice_up, got.last);
          end
        end
      end
      // input beats only come while the block is idle, so order with outputs is safe
      if (in_bus.valid && in_bus.ready)
        predict_beat(in_bus.kind, in_bus.ev_type, in_bus.ev_code, in_bus.ev_value,
                     in_bus.virt_id, in_bus.pos_x, in_bus.pos_y);
    end
    records_pending = expected_recs.size();
  end

endmodule

[bench/multitouch_slot_merger_core_test.sv]
`timescale 1ns / 1ps
module multitouch_slot_merger_core_test;

  localparam int SLOTS = 10;

  logic clk = 0;
  logic rst_n;
  int   fail_count, records_pending;
  int   send_idle_pct, recv_stall_pct;
  int   items_sent;

  mtsm_in_if  in_bus();
  mtsm_out_if out_bus();
  mtsm_cfg_if cfg_bus();

  multitouch_slot_merger_core dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus)
  );

  mtsm_merge_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus),
    .fail_count(fail_count), .records_pending(records_pending)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send(logic [1:0] kind, logic [15:0] typ, logic [15:0] code,
                      logic [31:0] val, logic [15:0] id, logic [16:0] px, logic [16:0] py);
    in_bus.kind     <= kind;
    in_bus.ev_type  <= typ;
    in_bus.ev_code  <= code;
    in_bus.ev_value <= val;
    in_bus.virt_id  <= id;
    in_bus.pos_x    <= px;
    in_bus.pos_y    <= py;
    in_bus.valid    <= 1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic phys(logic [15:0] typ, logic [15:0] code, logic [31:0] val);
    send(mtsm_pkg::KIND_PHYS, typ, code, val, 16'($urandom), 17'($urandom), 17'($urandom));
  endtask

  task automatic virt(logic [1:0] kind, logic [15:0] id, logic [16:0] px, logic [16:0] py);
    send(kind, 16'($urandom), 16'($urandom), $urandom, id, px, py);
  endtask

  // registers only change once the block has drained
  task automatic write_regs(logic [1:0] orient, logic [15:0] w, logic [15:0] h,
                            logic [15:0] t2s, logic [15:0] s2t, logic mon);
    logic [15:0] vals[6];
    logic [2:0]  idx[6];
    vals = '{16'(orient), w, h, t2s, s2t, 16'(mon)};
    idx  = '{mtsm_pkg::CFG_ORIENT, mtsm_pkg::CFG_SCR_W, mtsm_pkg::CFG_SCR_H,
             mtsm_pkg::CFG_T2S, mtsm_pkg::CFG_S2T, mtsm_pkg::CFG_MON};
    in_bus.valid <= 0;
    @(posedge clk);
    while (records_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_bus.index <= idx[i];
      cfg_bus.data  <= vals[i];
      cfg_bus.valid <= 1;
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
    end
    cfg_bus.valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'($urandom_range(65535, 70000));
      default: return 32'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [16:0] rand_pos();
    if ($urandom_range(7) == 0) return 17'($urandom);
    return 17'($urandom_range(0, 2500));
  endfunction

  function automatic logic [15:0] rand_id();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 6));
  endfunction

  task automatic random_run(int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_SLOT, 32'($urandom_range(0, 11)));
          if ($urandom_range(3) == 0) phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_TRACK, 32'hffff_ffff);
          else phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_TRACK, $urandom);
          phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_PX, rand_coord());
          phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_PY, rand_coord());
          phys(mtsm_pkg::TYPE_SYN, mtsm_pkg::CODE_SYN_REPORT, $urandom);
        end
        3, 4: virt(mtsm_pkg::KIND_DOWN, rand_id(), rand_pos(), rand_pos());
        5: virt(mtsm_pkg::KIND_MOVE, rand_id(), rand_pos(), rand_pos());
        6: virt(mtsm_pkg::KIND_UP, rand_id(), rand_pos(), rand_pos());
        7: phys(mtsm_pkg::TYPE_SYN, mtsm_pkg::CODE_SYN_REPORT, $urandom);
        8: send(2'($urandom), 16'($urandom), 16'($urandom), $urandom, 16'($urandom),
                17'($urandom), 17'($urandom));
        default: phys($urandom_range(1) ? mtsm_pkg::TYPE_ABS : 16'($urandom),
                      16'($urandom_range(0, 1) ? $urandom_range(16'h2f, 16'h39) : $urandom),
                      $urandom);
      endcase
    end
  endtask

  initial begin
    #2_000_000;
    $display("multitouch_slot_merger_core verification failed");
    $finish;
  end

  initial begin
    rst_n          <= 0;
    in_bus.valid   <= 0;
    in_bus.kind    <= mtsm_pkg::KIND_PHYS;
    in_bus.ev_type <= 0;
    in_bus.ev_code <= 0;
    in_bus.ev_value <= 0;
    in_bus.virt_id <= 0;
    in_bus.pos_x   <= 0;
    in_bus.pos_y   <= 0;
    cfg_bus.valid  <= 0;
    cfg_bus.index  <= mtsm_pkg::CFG_ORIENT;
    cfg_bus.data   <= 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: slot extremes, lift, saturation, ignored events, virtual down/move/up, full virtual table
    phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_SLOT, 32'd0);
    phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_TRACK, 32'd5);
    phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_PX, 32'h7fff_ffff);
    phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_PY, 32'h8000_0000);
    phys(mtsm_pkg::TYPE_SYN, mtsm_pkg::CODE_SYN_REPORT, 32'd0);
    phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_SLOT, 32'(SLOTS - 1));
    phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_TRACK, 32'd0);
    phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_PX, 32'd100);
    phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_SLOT, 32'(SLOTS));
    phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_SLOT, 32'hffff_ffff);
    phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_TRACK, 32'hffff_ffff);
    phys(16'hffff, 16'hffff, 32'hffff_ffff);
    phys(mtsm_pkg::TYPE_SYN, 16'd1, 32'd0);
    phys(mtsm_pkg::TYPE_SYN, mtsm_pkg::CODE_SYN_REPORT, 32'd0);
    virt(mtsm_pkg::KIND_UP, 16'd77, 17'd0, 17'd0);
    virt(mtsm_pkg::KIND_DOWN, 16'hffff, 17'h0ffff, 17'h10000);
    virt(mtsm_pkg::KIND_MOVE, 16'hffff, 17'd500, 17'd600);
    virt(mtsm_pkg::KIND_UP, 16'hffff, 17'd0, 17'd0);
    virt(mtsm_pkg::KIND_MOVE, 16'hffff, 17'd0, 17'd0);
    for (int i = 0; i < SLOTS + 1; i++)
      virt(mtsm_pkg::KIND_DOWN, 16'(i + 1), rand_pos(), rand_pos());
    for (int i = 0; i < SLOTS; i++) virt(mtsm_pkg::KIND_UP, 16'(i + 1), 17'd0, 17'd0);

    write_regs(2'd1, 16'd1080, 16'd2400, 16'd512, 16'd128, 1'b1);
    phys(mtsm_pkg::TYPE_ABS, mtsm_pkg::CODE_SLOT, 32'd2);
    phys(mtsm_pkg::TYPE_SYN, mtsm_pkg::CODE_SYN_REPORT, 32'd0);
    random_run(45);

    send_idle_pct = 61;
    write_regs(2'd3, 16'hffff, 16'd0, 16'hffff, 16'd1, 1'b1);
    random_run(45);

    send_idle_pct  = 0;
    recv_stall_pct = 61;
    write_regs(2'd2, 16'd0, 16'hffff, 16'd1, 16'hffff, 1'b0);
    random_run(45);

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    write_regs(2'd0, 16'd720, 16'd1280, 16'd300, 16'd0, 1'b1);
    random_run(45);

    in_bus.valid <= 0;
    @(posedge clk);
    while (records_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("multitouch_slot_merger_core verification clean");
    end else begin
      $display("multitouch_slot_merger_core verification failed");
    end
    $finish;
  end
endmodule
